[hdl/bilinear_2x_plane_upsampler_defines.svh]
// Assertion macros shared by the upsampler RTL
`ifndef BILINEAR_2X_PLANE_UPSAMPLER_DEFINES_SVH
`define BILINEAR_2X_PLANE_UPSAMPLER_DEFINES_SVH

// same-cycle implication, held off during reset
`define BU_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define BU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bu2x_pkg.sv]
// Shared constants, types and helpers of the 2x plane upsampler
package bu2x_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = 12;
    localparam int COORD_W = 12;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int LEVEL_W = Q_AW + 1;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [DIM_W-1:0] IN_WIDTH_RST  = DIM_W'(768);
    localparam logic [DIM_W-1:0] IN_HEIGHT_RST = DIM_W'(512);

    // register index = paddr[2]
    localparam logic REG_IN_WIDTH  = 1'b0;
    localparam logic REG_IN_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COL_W:0] w;
        logic [ROW_W:0] h;
    } t_dims;

    // one classified input pixel, everything the back end needs
    typedef struct packed {
        logic [PIX_W-1:0] l;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] vl;
        logic [PIX_W-1:0] dg;
        logic [PIX_W-1:0] hm;
        logic [PIX_W-1:0] vr;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col_m1;
        logic             has_top;
        logic             has_bot;
        logic             last_col;
        logic             frame_last;
    } t_job;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] mx);
        logic [DIM_W-1:0] res;
        if (v < DIM_W'(2)) begin
            res = DIM_W'(2);
        end else if (v > mx) begin
            res = mx;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

[hdl/bu2x_ifs.sv]
// Pixel and result channel interfaces
interface bu2x_pix_if import bu2x_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bu2x_res_if import bu2x_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [PIX_W-1:0]   value;
    logic               run_end;
    logic               frame_end;

    modport source (output valid, output out_row, output out_col, output value,
                    output run_end, output frame_end, input ready);
    modport sink   (input valid, input out_row, input out_col, input value,
                    input run_end, input frame_end, output ready);
endinterface

[hdl/bilinear_2x_plane_upsampler.sv]
// A result for an accepted pixel passes the stage-1 register, the job queue and
// the result register. Each pixel yields 0 to 12 results (none in column 0), one
// result per cycle on the output while the sink is ready. A 4-entry job queue
// lets input and output stall independently.
// Reset (synchronous, active low) clears counters, queue, output and sets the
// registers to 768 x 512; the line store is not cleared and needs no pass.
module bilinear_2x_plane_upsampler import bu2x_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    bu2x_pix_if.sink          i_pix,
    bu2x_res_if.source        o_res
);

    logic [DIM_W-1:0]   r_in_width;
    logic [DIM_W-1:0]   r_in_height;
    logic               cfg_wr;
    t_dims              dims;

    logic               push;
    t_job               job;
    logic               pop;
    logic               head_valid;
    t_job               head;
    logic [LEVEL_W-1:0] level;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width  <= IN_WIDTH_RST;
            r_in_height <= IN_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_IN_WIDTH:  r_in_width  <= pwdata[DIM_W-1:0];
                REG_IN_HEIGHT: r_in_height <= pwdata[DIM_W-1:0];
                default:       r_in_width  <= r_in_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IN_WIDTH:  prdata = APB_DW'(r_in_width);
            REG_IN_HEIGHT: prdata = APB_DW'(r_in_height);
            default:       prdata = '0;
        endcase
    end

    assign dims.w = (COL_W+1)'(clamp_dim(r_in_width, DIM_W'(MAX_WIDTH)));
    assign dims.h = (ROW_W+1)'(clamp_dim(r_in_height, DIM_W'(MAX_HEIGHT)));

    bu2x_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_dims    (dims),
        .i_restart (cfg_wr),
        .i_level   (level),
        .o_push    (push),
        .o_job     (job)
    );

    bu2x_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head),
        .o_level (level)
    );

    bu2x_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule

[hdl/bu2x_ram.sv]
// Generic single-write, single-read RAM with registered read-first output
module bu2x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bu2x_front.sv]
// Front end: takes pixels, tracks position, reads the line store, builds jobs
module bu2x_front import bu2x_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bu2x_pix_if.sink           i_pix,
    input  t_dims              i_dims,
    input  logic               i_restart,
    input  logic [LEVEL_W-1:0] i_level,
    output logic               o_push,
    output t_job               o_job
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_a_last;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [PIX_W-1:0] r_s1_l;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_top;
    logic             r_s1_bot;
    logic             r_s1_lastc;

    logic             accept;
    logic [COL_W-1:0] c_eff;
    logic [ROW_W-1:0] r_eff;
    logic             is_lastc;
    logic             is_lastr;
    logic [PIX_W-1:0] a1;
    logic [LEVEL_W:0] occupied;

    // a request is taken only if the queue can hold it and the one in flight
    assign occupied    = {1'b0, i_level} + (LEVEL_W+1)'(r_s1_valid);
    assign i_pix.ready = occupied < (LEVEL_W+1)'(Q_DEPTH);
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        if ({1'b0, r_col} >= i_dims.w || {1'b0, r_row} >= i_dims.h) begin
            c_eff = '0;
            r_eff = '0;
        end else begin
            c_eff = r_col;
            r_eff = r_row;
        end
        is_lastc = {1'b0, c_eff} == i_dims.w - 1'b1;
        is_lastr = {1'b0, r_eff} == i_dims.h - 1'b1;
        n_col    = c_eff + 1'b1;
        n_row    = r_eff;
        if (is_lastc) begin
            n_col = '0;
            n_row = is_lastr ? '0 : r_eff + 1'b1;
        end
    end

    // read-first store: the read sees the previous row, the write stores this one
    bu2x_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (c_eff),
        .i_wdata (i_pix.pixel),
        .i_re    (accept),
        .i_raddr (c_eff),
        .o_rdata (a1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (i_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_left <= i_pix.pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix   <= i_pix.pixel;
            r_s1_l     <= r_left;
            r_s1_col   <= c_eff;
            r_s1_row   <= r_eff;
            r_s1_top   <= r_eff != '0;
            r_s1_bot   <= is_lastr;
            r_s1_lastc <= is_lastc;
        end
        // previous column of the row above for the next pixel
        if (r_s1_valid) begin
            r_a_last <= a1;
        end
    end

    assign o_push = r_s1_valid && (r_s1_col != '0);

    always_comb begin
        o_job.l          = r_s1_l;
        o_job.pix        = r_s1_pix;
        o_job.vl         = PIX_W'((9'(r_a_last) + 9'(r_s1_l) + 9'd1) >> 1);
        o_job.dg         = PIX_W'((10'(r_a_last) + 10'(a1) + 10'(r_s1_l)
                                   + 10'(r_s1_pix) + 10'd2) >> 2);
        o_job.hm         = PIX_W'((9'(r_s1_l) + 9'(r_s1_pix) + 9'd1) >> 1);
        o_job.vr         = PIX_W'((9'(a1) + 9'(r_s1_pix) + 9'd1) >> 1);
        o_job.row        = r_s1_row;
        o_job.col_m1     = r_s1_col - 1'b1;
        o_job.has_top    = r_s1_top;
        o_job.has_bot    = r_s1_bot;
        o_job.last_col   = r_s1_lastc;
        o_job.frame_last = r_s1_bot && r_s1_lastc;
    end

endmodule

[hdl/bu2x_queue.sv]
// Short job queue between front and back end
`include "bilinear_2x_plane_upsampler_defines.svh"
module bu2x_queue import bu2x_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_job               i_job,
    input  logic               i_pop,
    output logic               o_valid,
    output t_job               o_head,
    output logic [LEVEL_W-1:0] o_level
);

    t_job               r_slot [Q_DEPTH];
    logic [Q_AW-1:0]    r_wp;
    logic [Q_AW-1:0]    r_rp;
    logic [LEVEL_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_slot[r_rp];
    assign o_level = r_count;

    `BU_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop, r_count != LEVEL_W'(Q_DEPTH), "job pushed into full queue")
    `BU_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "job popped from empty queue")
    `BU_ASSERT_NEXT(a_level_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue level lost a push")

endmodule

[hdl/bu2x_back.sv]
// Back end: walks each job's output pixels into the result register
`include "bilinear_2x_plane_upsampler_defines.svh"
module bu2x_back import bu2x_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_head_valid,
    input  t_job     i_head,
    output logic     o_pop,
    bu2x_res_if.source o_res
);

    // output row relative to the job's input row
    localparam logic [1:0] ROW_ABOVE = 2'd0;
    localparam logic [1:0] ROW_SAME  = 2'd1;
    localparam logic [1:0] ROW_BELOW = 2'd2;

    logic               r_grp;
    logic [1:0]         r_rph;
    logic               r_cb;

    logic               r_ov;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic [PIX_W-1:0]   r_val;
    logic               r_run_end;
    logic               r_frame_end;

    logic               fire;
    logic [1:0]         rs;
    logic [1:0]         rs_last;
    logic               rows_done;
    logic               last;
    logic [PIX_W-1:0]   val;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;

    assign fire      = i_head_valid && (!r_ov || o_res.ready);
    assign rs        = r_rph + {1'b0, !i_head.has_top};
    assign rs_last   = i_head.has_bot ? ROW_BELOW : ROW_SAME;
    assign rows_done = r_cb && (rs == rs_last);
    assign last      = rows_done && (r_grp == i_head.last_col);
    assign o_pop     = fire && last;

    always_comb begin
        case (rs)
            ROW_ABOVE: val = r_grp ? i_head.vr : (r_cb ? i_head.dg : i_head.vl);
            ROW_SAME:  val = r_grp ? i_head.pix : (r_cb ? i_head.hm : i_head.l);
            ROW_BELOW: val = r_grp ? i_head.pix : (r_cb ? i_head.hm : i_head.l);
            default:   val = i_head.pix;
        endcase
        row = COORD_W'({i_head.row, 1'b0}) + COORD_W'(rs) - COORD_W'(1);
        col = COORD_W'({COL_W'(i_head.col_m1 + COL_W'(r_grp)), r_cb});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_grp <= 1'b0;
            r_rph <= '0;
            r_cb  <= 1'b0;
        end else begin
            if (fire) begin
                r_ov <= 1'b1;
                r_cb <= !r_cb;
                if (rows_done) begin
                    r_rph <= '0;
                    r_grp <= last ? 1'b0 : 1'b1;
                end else if (r_cb) begin
                    r_rph <= r_rph + 1'b1;
                end
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_row       <= row;
            r_col       <= col;
            r_val       <= val;
            r_run_end   <= last;
            r_frame_end <= last && i_head.frame_last;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.out_row   = r_row;
    assign o_res.out_col   = r_col;
    assign o_res.value     = r_val;
    assign o_res.run_end   = r_run_end;
    assign o_res.frame_end = r_frame_end;

    `BU_ASSERT_IMP(a_frame_end_is_run_end, i_clk, i_rst_n, r_ov && r_frame_end, r_run_end, "frame end without run end")
    `BU_ASSERT_IMP(a_grp_only_last_col, i_clk, i_rst_n, i_head_valid && r_grp, i_head.last_col, "second column pair on inner pixel")
    `BU_ASSERT_IMP(a_row_sel_range, i_clk, i_rst_n, i_head_valid, rs != 2'd3 && !(rs == ROW_ABOVE && !i_head.has_top), "row select out of range")

endmodule

[sim/bu2x_checker.sv]
// Passive checker for the 2x plane upsampler: tracks registers, predicts pixels, compares results
module bu2x_checker import bu2x_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    bu2x_pix_if               i_pix,
    bu2x_res_if               i_res,
    output int                o_pending,
    output int                o_errors
);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   value;
        logic               run_end;
        logic               frame_end;
    } t_up_pixel;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    bit   [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] left_pix;
    int               col_pos;
    int               row_pos;
    t_up_pixel        due_pixels [$];
    int               err_cnt;

    function automatic int dim_used(input logic [DIM_W-1:0] v, input int mx);
        int d;
        d = v;
        if (d < 2) begin
            d = 2;
        end else if (d > mx) begin
            d = mx;
        end
        return d;
    endfunction

    function automatic t_up_pixel tag_pixel(input int row, input int col, input int val);
        t_up_pixel t;
        t.row       = COORD_W'(row);
        t.col       = COORD_W'(col);
        t.value     = PIX_W'(val);
        t.run_end   = 1'b0;
        t.frame_end = 1'b0;
        return t;
    endfunction

    // Expands one input pixel into the output pixels it completes.
    function automatic void upsample_pixel(input logic [PIX_W-1:0] pix);
        t_up_pixel outs [12];
        int n, w, h, c, r, l, p, a0, a1, base, hm, vm, i;
        n = 0;
        w = dim_used(width_reg, MAX_WIDTH);
        h = dim_used(height_reg, MAX_HEIGHT);
        p = pix;
        c = col_pos;
        r = row_pos;
        if (c >= w || r >= h) begin
            c = 0;
            r = 0;
        end
        if (c > 0) begin
            l    = left_pix;
            a0   = line_mem[c-1];
            a1   = line_mem[c];
            base = 2 * (c - 1);
            hm   = (l + p + 1) >> 1;
            if (r > 0) begin
                outs[n] = tag_pixel(2*r - 1, base, (a0 + l + 1) >> 1);
                n++;
                outs[n] = tag_pixel(2*r - 1, base + 1, (a0 + a1 + l + p + 2) >> 2);
                n++;
            end
            outs[n] = tag_pixel(2*r, base, l);
            n++;
            outs[n] = tag_pixel(2*r, base + 1, hm);
            n++;
            if (r == h - 1) begin
                outs[n] = tag_pixel(2*r + 1, base, l);
                n++;
                outs[n] = tag_pixel(2*r + 1, base + 1, hm);
                n++;
            end
            line_mem[c-1] = PIX_W'(l);

            // right edge: replicate the last original / vertical mean
            if (c == w - 1) begin
                base = 2 * c;
                if (r > 0) begin
                    vm = (a1 + p + 1) >> 1;
                    outs[n] = tag_pixel(2*r - 1, base, vm);
                    n++;
                    outs[n] = tag_pixel(2*r - 1, base + 1, vm);
                    n++;
                end
                outs[n] = tag_pixel(2*r, base, p);
                n++;
                outs[n] = tag_pixel(2*r, base + 1, p);
                n++;
                if (r == h - 1) begin
                    outs[n] = tag_pixel(2*r + 1, base, p);
                    n++;
                    outs[n] = tag_pixel(2*r + 1, base + 1, p);
                    n++;
                end
                line_mem[c] = pix;
            end
        end
        if (n > 0) begin
            outs[n-1].run_end   = 1'b1;
            outs[n-1].frame_end = (r == h - 1) && (c == w - 1);
        end
        for (i = 0; i < n; i++) begin
            due_pixels.push_back(outs[i]);
        end

        left_pix = pix;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endfunction

    function automatic void check_field(input string what, input logic [COORD_W-1:0] want,
                                        input logic [COORD_W-1:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_up_pixel want;
        if (!i_rst_n) begin
            width_reg  = IN_WIDTH_RST;
            height_reg = IN_HEIGHT_RST;
            left_pix   = '0;
            col_pos    = 0;
            row_pos    = 0;
            err_cnt    = 0;
            due_pixels.delete();
        end else begin
            // any register write restarts the plane
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_IN_WIDTH) begin
                    width_reg = i_pwdata[DIM_W-1:0];
                end else begin
                    height_reg = i_pwdata[DIM_W-1:0];
                end
                col_pos = 0;
                row_pos = 0;
            end
            if (i_pix.valid && i_pix.ready) begin
                upsample_pixel(i_pix.pixel);
            end
            if (i_res.valid && i_res.ready) begin
                if (due_pixels.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result expected none got row %0d col %0d value %0d",
                             $time, i_res.out_row, i_res.out_col, i_res.value);
                end else begin
                    want = due_pixels.pop_front();
                    check_field("out_row", want.row, i_res.out_row);
                    check_field("out_col", want.col, i_res.out_col);
                    check_field("value", want.value, i_res.value);
                    check_field("run_end", want.run_end, i_res.run_end);
                    check_field("frame_end", want.frame_end, i_res.frame_end);
                end
            end
        end
        o_pending <= due_pixels.size();
        o_errors  <= err_cnt;
    end

endmodule

[sim/tb_top.sv]
// Regression top for the 2x plane upsampler: clock, reset, stimulus, watchdog and verdict
module tb_top;
    import bu2x_pkg::*;

    localparam int RAND_PIXELS   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int TAIL_CYCLES   = 20;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic              pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;

    int due_count;
    int fail_count;
    int burst_left;
    bit steady_feed;
    int hold_reqs;
    int quiet_cycles;
    int width_val;
    int height_val;

    bu2x_pix_if pix_ch ();
    bu2x_res_if res_ch ();

    bilinear_2x_plane_upsampler u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    bu2x_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_pix     (pix_ch),
        .i_res     (res_ch),
        .o_pending (due_count),
        .o_errors  (fail_count)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int eff_dim(input int v, input int mx);
        return (v < 2) ? 2 : ((v > mx) ? mx : v);
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] v);
        if (burst_left <= 0 && !steady_feed) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= v;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        burst_left--;
    endtask

    // setup + access, then the bus goes idle before returning so back-to-back writes never collide
    task automatic reg_write(input logic idx, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= {(APB_DW-DIM_W)'($urandom()), DIM_W'(val)};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IN_WIDTH) begin
            width_val = val & ((1 << DIM_W) - 1);
        end else begin
            height_val = val & ((1 << DIM_W) - 1);
        end
        @(posedge i_clk);
    endtask

    // column-0 pixels produce nothing, so the wait runs on past the last result
    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result sink: random stall patterns, plus a long hold-off on request
    initial begin : res_drain
        int mode, span, holds_done;
        holds_done = 0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_reqs != holds_done) begin
                holds_done = hold_reqs;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                repeat (span) begin
                    case (mode)
                        0:       res_ch.ready <= 1'b1;
                        1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                        2:       res_ch.ready <= 1'($urandom_range(0, 1));
                        default: res_ch.ready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("bilinear_2x_plane_upsampler regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int               dir_px [$];
        int               w_new, h_new, n_items, kind, phase, rand_sent, pick, order, plane, k;
        bit               big;
        logic [PIX_W-1:0] pv;

        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= '0;
        burst_left   = 0;
        steady_feed  = 1'b0;
        hold_reqs    = 0;
        width_val    = IN_WIDTH_RST;
        height_val   = IN_HEIGHT_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset dimensions: start of row 0 only
        dir_px = '{0, 255, 255, 0};
        foreach (dir_px[i]) send_pixel(PIX_W'(dir_px[i]));
        wait_drained();

        // 2x2 plane: last pixel closes bottom and right edges at once
        reg_write(REG_IN_WIDTH, 2);
        reg_write(REG_IN_HEIGHT, 2);
        dir_px = '{0, 255, 255, 0};
        foreach (dir_px[i]) send_pixel(PIX_W'(dir_px[i]));
        wait_drained();

        // 3x3 plane with odd sums for rounding, then wrap into the next plane
        reg_write(REG_IN_WIDTH, 3);
        reg_write(REG_IN_HEIGHT, 3);
        dir_px = '{1, 2, 254, 255, 0, 3, 128, 127, 255, 9, 200};
        foreach (dir_px[i]) send_pixel(PIX_W'(dir_px[i]));
        wait_drained();

        // below-range values clamp to 2; also restarts the half-done plane
        reg_write(REG_IN_WIDTH, 1);
        reg_write(REG_IN_HEIGHT, 0);
        dir_px = '{255, 254, 1, 0};
        foreach (dir_px[i]) send_pixel(PIX_W'(dir_px[i]));

        phase     = 0;
        rand_sent = 0;
        pv        = '0;
        while (rand_sent < RAND_PIXELS) begin
            wait_drained();
            pick = $urandom_range(0, 15);
            big  = 1'b0;
            case (pick)
                0: begin
                    w_new = $urandom_range(0, 1) ? MAX_WIDTH : $urandom_range(MAX_WIDTH + 1, 4095);
                    h_new = $urandom_range(2, 5);
                    big   = 1'b1;
                end
                1: begin
                    w_new = 2;
                    h_new = $urandom_range(0, 1) ? MAX_HEIGHT : $urandom_range(MAX_HEIGHT + 1, 4095);
                    big   = 1'b1;
                end
                2: begin
                    w_new = $urandom_range(0, 1);
                    h_new = $urandom_range(2, 5);
                end
                3: begin
                    w_new = $urandom_range(2, 7);
                    h_new = $urandom_range(0, 1);
                end
                default: begin
                    w_new = $urandom_range(2, 7);
                    h_new = $urandom_range(2, 5);
                end
            endcase

            // 0: width only, 1: height only, 2: width then height, 3: height then width
            order = $urandom_range((pick <= 3) ? 2 : 0, 3);
            if (order == 3) reg_write(REG_IN_HEIGHT, h_new);
            if (order != 1) reg_write(REG_IN_WIDTH, w_new);
            if (order == 1 || order == 2) reg_write(REG_IN_HEIGHT, h_new);

            plane = eff_dim(width_val, MAX_WIDTH) * eff_dim(height_val, MAX_HEIGHT);
            if (big) begin
                n_items = $urandom_range(20, 60);
            end else if ($urandom_range(0, 9) < 7) begin
                n_items = plane * $urandom_range(1, 2);
            end else begin
                n_items = $urandom_range(1, plane + 3);
            end

            // keep requests coming while the sink holds off so the input backs up
            if (phase == 1) begin
                steady_feed = 1'b1;
                hold_reqs++;
                if (n_items < 60) n_items = 60;
            end
            if (n_items > RAND_PIXELS - rand_sent) n_items = RAND_PIXELS - rand_sent;

            kind = $urandom_range(0, 2);
            for (k = 0; k < n_items; k++) begin
                if (phase % 4 == 2 && k == n_items / 2) wait_drained();
                case (kind)
                    0:       pv = PIX_W'($urandom());
                    1:       pv = ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ PIX_W'($urandom_range(0, 1));
                    default: pv = pv + PIX_W'($urandom_range(0, 6)) - PIX_W'(3);
                endcase
                send_pixel(pv);
            end
            steady_feed = 1'b0;
            rand_sent += n_items;
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("bilinear_2x_plane_upsampler regression: pass");
        end else begin
            $display("bilinear_2x_plane_upsampler regression: fail");
        end
        $finish;
    end

endmodule
